// ----- sv/ibfr_pkg.sv -----
// Package with the transaction types and frame constants of the iBUS frame receiver.
`default_nettype none

package ibfr_pkg;

    localparam int NUM_CHANNELS = 14;
    localparam int CH_IDX_W     = 4;
    localparam int GAP_W        = 20;
    localparam int SUM_W        = 17;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [7:0]          HEADER_BYTE  = 8'h20;
    localparam logic [7:0]          COMMAND_BYTE = 8'h40;
    localparam logic [SUM_W-1:0]    SUM_TARGET   = 17'h0FFFF;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 20'd3000;
    localparam logic [CH_IDX_W-1:0] LAST_CHANNEL = 4'd13;

    localparam logic [APB_ADDR_W-1:0] REG_FRAME_GAP = 3'd0;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_time_us;
    } in_item_t;

    typedef struct packed {
        logic [CH_IDX_W-1:0] channel_index;
        logic [15:0]         channel_value;
        logic                status;
        logic                last;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/ibus_frame_receiver_unit.sv -----
// A checksum-error result is shown in the cycle after the final byte; a good frame shows its
// first channel after the read state, the registered memory read and the out state.
// Throughput: one byte per cycle while no burst runs and, for the final byte, the output is free;
// a good frame then gives 14 results, each after a read of the channel memory, and no byte is
// taken during that burst. Reset is synchronous and active low: it clears the parser and sum,
// the deadline, burst and output valid and sets the gap to 3000 us; channel memory is not cleared.
`default_nettype none

module ibus_frame_receiver_unit
    import ibfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HEADER    = 3'd1;
    localparam logic [2:0] PH_COMMAND   = 3'd2;
    localparam logic [2:0] PH_DATA_LOW  = 3'd3;
    localparam logic [2:0] PH_DATA_HIGH = 3'd4;
    localparam logic [2:0] PH_CRC_LOW   = 3'd5;
    localparam logic [2:0] PH_CRC_HIGH  = 3'd6;

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_READ = 2'd1;
    localparam logic [1:0] BS_OUT  = 2'd2;

    logic [15:0] chan_mem [NUM_CHANNELS];

    logic [GAP_W-1:0]    gap_reg;
    logic [2:0]          phase_reg, phase_next;
    logic [CH_IDX_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [31:0]         deadline_reg, deadline_next;
    logic [7:0]          low_byte_reg, low_byte_next;
    logic [1:0]          burst_reg, burst_next;
    logic [CH_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [15:0]         rd_data_reg;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic        in_accept;
    logic        out_free;
    logic [31:0] gap_diff;
    logic        start;
    logic        mem_we;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (burst_reg == BS_IDLE) && ((phase_reg != PH_CRC_HIGH) || out_free);
    assign in_accept = s_valid && s_ready;
    assign gap_diff  = s_data.arrival_time_us - deadline_reg;
    assign start     = (gap_diff != 32'd0) && !gap_diff[31];

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_FRAME_GAP[APB_ADDR_W-1:2])
                   ? {{(APB_DATA_W-GAP_W){1'b0}}, gap_reg} : '0;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        deadline_next = deadline_reg;
        low_byte_next = low_byte_reg;
        burst_next    = burst_reg;
        rd_idx_next   = rd_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;

        if (in_accept) begin
            deadline_next = s_data.arrival_time_us + {{(32-GAP_W){1'b0}}, gap_reg};
            if (start) begin
                if (s_data.rx_byte == HEADER_BYTE) begin
                    phase_next = PH_HEADER;
                    sum_next   = {{(SUM_W-8){1'b0}}, HEADER_BYTE};
                end else begin
                    phase_next = PH_IDLE;
                end
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (s_data.rx_byte == COMMAND_BYTE) begin
                            sum_next   = sum_reg + {{(SUM_W-8){1'b0}}, COMMAND_BYTE};
                            count_next = '0;
                            phase_next = PH_COMMAND;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_COMMAND, PH_DATA_LOW: begin
                        sum_next      = sum_reg + {{(SUM_W-8){1'b0}}, s_data.rx_byte};
                        low_byte_next = s_data.rx_byte;
                        phase_next    = PH_DATA_HIGH;
                    end
                    PH_DATA_HIGH: begin
                        sum_next = sum_reg + {{(SUM_W-8){1'b0}}, s_data.rx_byte};
                        if (count_reg < CH_IDX_W'(NUM_CHANNELS)) begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end else begin
                            count_next = CH_IDX_W'(NUM_CHANNELS);
                        end
                        phase_next = (count_next >= CH_IDX_W'(NUM_CHANNELS))
                                   ? PH_CRC_LOW : PH_DATA_LOW;
                    end
                    PH_CRC_LOW: begin
                        sum_next   = sum_reg + {{(SUM_W-8){1'b0}}, s_data.rx_byte};
                        phase_next = PH_CRC_HIGH;
                    end
                    PH_CRC_HIGH: begin
                        sum_next   = sum_reg + {1'b0, s_data.rx_byte, 8'h00};
                        phase_next = PH_IDLE;
                        if (sum_next == SUM_TARGET) begin
                            burst_next  = BS_READ;
                            rd_idx_next = '0;
                        end else begin
                            m_valid_next              = 1'b1;
                            m_data_next.channel_index = '0;
                            m_data_next.channel_value = '0;
                            m_data_next.status        = 1'b1;
                            m_data_next.last          = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        unique case (burst_reg)
            BS_READ: begin
                burst_next = BS_OUT;
            end
            BS_OUT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.channel_index = rd_idx_reg;
                    m_data_next.channel_value = rd_data_reg;
                    m_data_next.status        = 1'b0;
                    m_data_next.last          = (rd_idx_reg == LAST_CHANNEL);
                    if (rd_idx_reg == LAST_CHANNEL) begin
                        burst_next = BS_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        burst_next  = BS_READ;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // No byte is taken during a burst, so a write never meets a read whose data the burst uses.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            chan_mem[count_reg] <= {s_data.rx_byte, low_byte_reg};
        end
        rd_data_reg <= chan_mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg      <= GAP_RESET;
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            deadline_reg <= '0;
            burst_reg    <= BS_IDLE;
            rd_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_FRAME_GAP[APB_ADDR_W-1:2])) begin
                gap_reg <= pwdata[GAP_W-1:0];
            end
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            deadline_reg <= deadline_next;
            burst_reg    <= burst_next;
            rd_idx_reg   <= rd_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_byte_reg <= low_byte_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

// ----- sv/ibfr_checker.sv -----
// Port-level checker for the iBUS frame receiver, with its bind statement.
`default_nettype none

module ibfr_checker
    import ibfr_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data,
    input wire logic      pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transaction changed while stalled.");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.channel_index <= LAST_CHANNEL)
        else $error("Channel index out of range.");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.last && m_data.channel_index == '0
            && m_data.channel_value == '0)
        else $error("Malformed checksum-error transaction.");

    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.status |-> m_data.last == (m_data.channel_index == LAST_CHANNEL))
        else $error("Last flag does not match the final channel.");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("Configuration port stalled.");

endmodule

bind ibus_frame_receiver_unit ibfr_checker u_ibfr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

`default_nettype wire

// ----- bench/tb_ibus_frame_receiver_unit.sv -----
// Self-checking testbench for the iBUS frame receiver, driven with directed and random bytes.
`default_nettype none

module tb_ibus_frame_receiver_unit;
    import ibfr_pkg::*;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_HEADER,
        RX_COMMAND,
        RX_DATA_LO,
        RX_DATA_HI,
        RX_SUM_LO,
        RX_SUM_HI
    } rx_phase_t;

    localparam int FRAME_BYTES  = 32;
    localparam int DRAIN_CYCLES = 8;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [GAP_W-1:0] frame_gap;
    rx_phase_t        rx_phase;
    logic [3:0]       chan_count;
    logic [SUM_W-1:0] byte_sum;
    logic [31:0]      gap_deadline;
    logic [15:0]      chan_store [NUM_CHANNELS];

    out_item_t   expected_channels [$];
    out_item_t   channel_wanted;
    logic [31:0] last_arrival_us;
    logic [15:0] tx_channels [NUM_CHANNELS];
    int          mismatch_count   = 0;
    int          frame_bytes_sent = 0;
    bit          steady_flow      = 1'b0;

    ibus_frame_receiver_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 34);
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_channels.size() == 0) begin
                note_mismatch("result transaction with nothing expected");
            end else begin
                channel_wanted = expected_channels.pop_front();
                if (m_data.channel_index !== channel_wanted.channel_index) begin
                    note_mismatch($sformatf("channel_index got %0d want %0d",
                        m_data.channel_index, channel_wanted.channel_index));
                end
                if (m_data.channel_value !== channel_wanted.channel_value) begin
                    note_mismatch($sformatf("channel_value got %h want %h",
                        m_data.channel_value, channel_wanted.channel_value));
                end
                if (m_data.status !== channel_wanted.status) begin
                    note_mismatch($sformatf("status got %b want %b",
                        m_data.status, channel_wanted.status));
                end
                if (m_data.last !== channel_wanted.last) begin
                    note_mismatch($sformatf("last got %b want %b",
                        m_data.last, channel_wanted.last));
                end
            end
        end
    end

    task automatic reset_decoder();
        frame_gap       = GAP_RESET;
        rx_phase        = RX_IDLE;
        chan_count      = '0;
        byte_sum        = '0;
        gap_deadline    = '0;
        last_arrival_us = '0;
    endtask

    task automatic decode_rx_byte(input logic [7:0] rx, input logic [31:0] when_us);
        logic [31:0] lag;
        logic        opens;
        out_item_t   res;
        lag             = when_us - gap_deadline;
        opens           = (lag != 32'd0) && !lag[31];
        gap_deadline    = when_us + 32'(frame_gap);
        last_arrival_us = when_us;
        if (opens) begin
            if (rx == HEADER_BYTE) begin
                rx_phase = RX_HEADER;
                byte_sum = SUM_W'(HEADER_BYTE);
            end else begin
                rx_phase = RX_IDLE;
            end
        end else begin
            case (rx_phase)
                RX_HEADER: begin
                    if (rx == COMMAND_BYTE) begin
                        byte_sum   = byte_sum + SUM_W'(COMMAND_BYTE);
                        chan_count = '0;
                        rx_phase   = RX_COMMAND;
                    end else begin
                        rx_phase = RX_IDLE;
                    end
                end
                RX_COMMAND, RX_DATA_LO: begin
                    byte_sum = byte_sum + SUM_W'(rx);
                    if (chan_count < NUM_CHANNELS) begin
                        chan_store[chan_count] = {8'h00, rx};
                    end
                    rx_phase = RX_DATA_HI;
                end
                RX_DATA_HI: begin
                    byte_sum = byte_sum + SUM_W'(rx);
                    if (chan_count < NUM_CHANNELS) begin
                        chan_store[chan_count][15:8] = rx;
                        chan_count = chan_count + 4'd1;
                    end else begin
                        chan_count = 4'(NUM_CHANNELS);
                    end
                    rx_phase = (chan_count >= NUM_CHANNELS) ? RX_SUM_LO : RX_DATA_LO;
                end
                RX_SUM_LO: begin
                    byte_sum = byte_sum + SUM_W'(rx);
                    rx_phase = RX_SUM_HI;
                end
                RX_SUM_HI: begin
                    byte_sum = byte_sum + {1'b0, rx, 8'h00};
                    if (byte_sum == SUM_TARGET) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            res.channel_index = CH_IDX_W'(i);
                            res.channel_value = chan_store[i];
                            res.status        = 1'b0;
                            res.last          = (CH_IDX_W'(i) == LAST_CHANNEL);
                            expected_channels.push_back(res);
                        end
                    end else begin
                        res        = '0;
                        res.status = 1'b1;
                        res.last   = 1'b1;
                        expected_channels.push_back(res);
                    end
                    rx_phase = RX_IDLE;
                end
                default: begin
                    rx_phase = RX_IDLE;
                end
            endcase
        end
    endtask

    function automatic bit sender_rests();
        return !steady_flow && ($urandom_range(0, 99) < 34);
    endfunction

    function automatic logic [31:0] start_lead();
        return 32'($urandom_range(1, 1000));
    endfunction

    task automatic send_rx_byte(input logic [7:0] rx, input logic [31:0] when_us);
        while (sender_rests()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_item_t'{rx, when_us};
        do @(posedge aclk); while (!s_ready);
        decode_rx_byte(rx, when_us);
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (expected_channels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_frame_gap(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FRAME_GAP;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        frame_gap = value[GAP_W-1:0];
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(frame_gap)) begin
            note_mismatch($sformatf("frame_gap_us read %h want %h", prdata, frame_gap));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_random_channels();
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            case ($urandom_range(0, 9))
                0:       tx_channels[i] = 16'h0000;
                1:       tx_channels[i] = 16'hFFFF;
                default: tx_channels[i] = 16'($urandom);
            endcase
        end
    endtask

    task automatic send_frame(input logic [7:0] command, input bit corrupt,
                              input int byte_count, input logic [31:0] lead_us);
        logic [7:0]  frame_bytes [FRAME_BYTES];
        logic [15:0] check;
        logic [31:0] span;
        logic [31:0] when_us;
        frame_bytes[0] = HEADER_BYTE;
        frame_bytes[1] = command;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            frame_bytes[2 + 2 * i] = tx_channels[i][7:0];
            frame_bytes[3 + 2 * i] = tx_channels[i][15:8];
        end
        check = 16'h0000;
        for (int k = 0; k < FRAME_BYTES - 2; k++) begin
            check = check + 16'(frame_bytes[k]);
        end
        check = 16'hFFFF - check;
        if (corrupt) begin
            check = check ^ 16'($urandom_range(1, 65535));
        end
        frame_bytes[FRAME_BYTES - 2] = check[7:0];
        frame_bytes[FRAME_BYTES - 1] = check[15:8];
        for (int k = 0; k < byte_count; k++) begin
            if (k == 0) begin
                when_us = gap_deadline + lead_us;
            end else begin
                span    = gap_deadline - last_arrival_us;
                when_us = last_arrival_us +
                          (($urandom_range(0, 7) == 0) ? span : 32'($urandom_range(0, span)));
            end
            send_rx_byte(frame_bytes[k], when_us);
            frame_bytes_sent++;
        end
    endtask

    task automatic test_stray_bytes();
        send_rx_byte(HEADER_BYTE, 32'd0);
        send_rx_byte(8'hFF, 32'd2999);
        send_rx_byte(8'h00, 32'd9000);
        send_rx_byte(COMMAND_BYTE, 32'd9001);
    endtask

    task automatic test_wrong_command();
        send_rx_byte(HEADER_BYTE, 32'd20000);
        send_rx_byte(8'hBF, 32'd20100);
        send_rx_byte(8'h55, 32'd20200);
        send_rx_byte(COMMAND_BYTE, 32'd20300);
    endtask

    task automatic test_restart_mid_frame();
        load_random_channels();
        send_frame(COMMAND_BYTE, 1'b0, 9, start_lead());
        send_rx_byte(8'h7E, gap_deadline + 32'd1);
        send_rx_byte(8'h12, last_arrival_us);
        send_frame(COMMAND_BYTE, 1'b0, 20, start_lead());
        send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, start_lead());
    endtask

    task automatic test_extreme_frames();
        for (int i = 0; i < NUM_CHANNELS; i++) tx_channels[i] = 16'h0000;
        send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, start_lead());
        for (int i = 0; i < NUM_CHANNELS; i++) tx_channels[i] = 16'hFFFF;
        send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, start_lead());
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            tx_channels[i] = i[0] ? 16'hAA55 : 16'h55AA;
        end
        send_frame(COMMAND_BYTE, 1'b1, FRAME_BYTES, start_lead());
    endtask

    task automatic test_timestamp_wrap();
        send_rx_byte(HEADER_BYTE, 32'hFFFF_0000);
        load_random_channels();
        send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, 32'h0000_F400);
        send_rx_byte(HEADER_BYTE, gap_deadline + 32'h8000_0000);
        load_random_channels();
        send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, 32'h7FFF_FFFF);
    endtask

    task automatic test_gap_settings();
        logic [APB_DATA_W-1:0] gap_values [3];
        gap_values = '{32'd0, 32'h000F_FFFF, 32'hFFF0_07D0};
        foreach (gap_values[g]) begin
            pause_until_drained();
            write_frame_gap(gap_values[g]);
            load_random_channels();
            send_frame(COMMAND_BYTE, (g == 1), FRAME_BYTES, start_lead());
        end
    endtask

    task automatic test_random_traffic();
        logic [APB_DATA_W-1:0] phase_gaps [3];
        logic [7:0]            command;
        int                    goal;
        int                    pick;
        phase_gaps = '{32'(GAP_RESET), 32'($urandom_range(1, 1000000)),
                       32'($urandom_range(1, 64))};
        foreach (phase_gaps[p]) begin
            pause_until_drained();
            write_frame_gap(phase_gaps[p]);
            steady_flow = (p == 1);
            goal = frame_bytes_sent + ((p == 1) ? 40 : 8);
            while (frame_bytes_sent < goal) begin
                pick = $urandom_range(0, 99);
                load_random_channels();
                if (pick < 60) begin
                    send_frame(COMMAND_BYTE, 1'b0, FRAME_BYTES, start_lead());
                end else if (pick < 72) begin
                    send_frame(COMMAND_BYTE, 1'b1, FRAME_BYTES, start_lead());
                end else if (pick < 80) begin
                    send_frame(COMMAND_BYTE, 1'b0, $urandom_range(1, FRAME_BYTES - 1),
                               start_lead());
                end else if (pick < 86) begin
                    command = 8'($urandom);
                    if (command == COMMAND_BYTE) command = ~command;
                    send_frame(command, 1'b0, FRAME_BYTES, start_lead());
                end else begin
                    repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom), $urandom);
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        reset_decoder();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_stray_bytes();
        test_wrong_command();
        test_restart_mid_frame();
        test_extreme_frames();
        test_timestamp_wrap();
        test_gap_settings();
        test_random_traffic();
        pause_until_drained();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("ibus_frame_receiver_unit test passed");
        end else begin
            $display("ibus_frame_receiver_unit test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("ibus_frame_receiver_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
